// ----- src/i2cm_pkg.sv -----
// Shared types, phase codes and register indexes for the I2C register-burst master.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  localparam int unsigned PHASE_W = 5;
  localparam int unsigned TICK_W  = 17;
  localparam int unsigned BIT_W   = 4;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd100;
  localparam logic [7:0]  ACK_POLLS_RST   = 8'd50;

  localparam logic CFG_PHASE_TICKS = 1'b0;
  localparam logic CFG_ACK_POLLS   = 1'b1;

  localparam logic [PHASE_W-1:0] PH_IDLE   = 5'd0;
  localparam logic [PHASE_W-1:0] PH_ST_A   = 5'd1;
  localparam logic [PHASE_W-1:0] PH_ST_B   = 5'd2;
  localparam logic [PHASE_W-1:0] PH_ST_C   = 5'd3;
  localparam logic [PHASE_W-1:0] PH_RS_P   = 5'd4;
  localparam logic [PHASE_W-1:0] PH_RS_A   = 5'd5;
  localparam logic [PHASE_W-1:0] PH_RS_B   = 5'd6;
  localparam logic [PHASE_W-1:0] PH_RS_C   = 5'd7;
  localparam logic [PHASE_W-1:0] PH_TXA_L  = 5'd8;
  localparam logic [PHASE_W-1:0] PH_TXA_H  = 5'd9;
  localparam logic [PHASE_W-1:0] PH_TXR_L  = 5'd10;
  localparam logic [PHASE_W-1:0] PH_TXR_H  = 5'd11;
  localparam logic [PHASE_W-1:0] PH_TXD_L  = 5'd12;
  localparam logic [PHASE_W-1:0] PH_TXD_H  = 5'd13;
  localparam logic [PHASE_W-1:0] PH_TXAR_L = 5'd14;
  localparam logic [PHASE_W-1:0] PH_TXAR_H = 5'd15;
  localparam logic [PHASE_W-1:0] PH_RX_L   = 5'd16;
  localparam logic [PHASE_W-1:0] PH_RX_H   = 5'd17;
  localparam logic [PHASE_W-1:0] PH_P_L    = 5'd18;
  localparam logic [PHASE_W-1:0] PH_P_H    = 5'd19;
  localparam logic [PHASE_W-1:0] PH_P_R    = 5'd20;
  localparam logic [PHASE_W-1:0] PH_F_L    = 5'd21;
  localparam logic [PHASE_W-1:0] PH_F_H    = 5'd22;
  localparam logic [PHASE_W-1:0] PH_F_R    = 5'd23;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [TICK_W-1:0]  tick;
    logic [BIT_W-1:0]   bit_idx;
    logic [7:0]         shift;
    logic [7:0]         left;
    logic [7:0]         poll;
    logic [6:0]         dev;
    logic [7:0]         regad;
    logic               dir;
  } ctl_t;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [7:0]  ack_polls;
  } cfg_t;

  typedef struct packed {
    logic       go;
    logic       func;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] wr_byte;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       byte_taken;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       done_res;
    logic       status;
  } res_t;

endpackage

`default_nettype wire

// ----- src/i2cm_cfg.sv -----
// Configuration registers: phase length and acknowledge poll limit.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_cfg
  import i2cm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  output cfg_t             cfg_o
);

  logic [15:0] phase_ticks_q;
  logic [7:0]  ack_polls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PHASE_TICKS_RST;
      ack_polls_q   <= ACK_POLLS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PHASE_TICKS: phase_ticks_q <= cfg_data_i;
        CFG_ACK_POLLS:   ack_polls_q   <= cfg_data_i[7:0];
        default:         ;
      endcase
    end
  end

  assign cfg_o.phase_ticks = phase_ticks_q;
  assign cfg_o.ack_polls   = ack_polls_q;

endmodule

`default_nettype wire

// ----- src/i2cm_step.sv -----
// Next-state and pin logic for one bus tick of the I2C register-burst master.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_step
  import i2cm_pkg::*;
(
  input  ctl_t ctl_i,
  input  cfg_t cfg_i,
  input  req_t req_i,
  output ctl_t ctl_o,
  output res_t res_o
);

  logic [15:0]        plen;
  logic [TICK_W-1:0]  len;
  logic [TICK_W:0]    tick_inc;
  logic               in_tx;
  logic               ack;
  logic               taken;
  logic               valid;
  logic               done;
  logic               fail;
  logic [BIT_W-1:0]   bit_inc;
  logic [PHASE_W-1:0] s;

  always_comb begin
    ctl_o    = ctl_i;
    taken    = 1'b0;
    valid    = 1'b0;
    done     = 1'b0;
    fail     = 1'b0;
    plen     = (cfg_i.phase_ticks == 16'd0) ? 16'd1 : cfg_i.phase_ticks;
    len      = ((ctl_i.phase == PH_RX_L || ctl_i.phase == PH_RX_H) && ctl_i.bit_idx < 4'd8)
               ? {plen, 1'b0} : {1'b0, plen};
    tick_inc = {1'b0, ctl_i.tick} + 18'd1;
    in_tx    = ctl_i.phase inside {[PH_TXA_L:PH_TXAR_H]};
    ack      = !req_i.sda_in;
    bit_inc  = ctl_i.bit_idx + 4'd1;

    if (ctl_i.phase == PH_IDLE) begin
      if (req_i.go) begin
        ctl_o.dev   = req_i.dev_addr;
        ctl_o.regad = req_i.reg_addr;
        ctl_o.dir   = req_i.func;
        ctl_o.left  = req_i.byte_count;
        ctl_o.tick  = '0;
        ctl_o.phase = PH_ST_A;
      end
    end else if (tick_inc < {1'b0, len}) begin
      ctl_o.tick = tick_inc[TICK_W-1:0];
    end else begin
      ctl_o.tick = '0;
      if (in_tx) begin
        if (!ctl_i.phase[0]) begin
          if (ctl_i.bit_idx >= 4'd8) ctl_o.poll = '0;
          ctl_o.phase = ctl_i.phase + 5'd1;
        end else if (ctl_i.bit_idx < 4'd8) begin
          ctl_o.shift   = {ctl_i.shift[6:0], 1'b0};
          ctl_o.bit_idx = bit_inc;
          ctl_o.phase   = ctl_i.phase - 5'd1;
        end else if (req_i.sda_in && ctl_i.poll < cfg_i.ack_polls) begin
          ctl_o.poll = ctl_i.poll + 8'd1;
        end else begin
          case (ctl_i.phase)
            PH_TXA_H: begin
              if (ack) begin
                ctl_o.phase   = PH_TXR_L;
                ctl_o.shift   = ctl_i.regad;
                ctl_o.bit_idx = '0;
              end else begin
                ctl_o.phase = PH_F_L;
              end
            end
            PH_TXR_H, PH_TXD_H: begin
              if (ctl_i.phase == PH_TXR_H && ctl_i.dir) begin
                ctl_o.phase = PH_RS_P;
              end else if ((ctl_i.phase == PH_TXD_H && !ack) || ctl_i.left == 8'd0) begin
                ctl_o.phase = PH_P_L;
              end else begin
                ctl_o.phase   = PH_TXD_L;
                ctl_o.shift   = req_i.wr_byte;
                ctl_o.bit_idx = '0;
                ctl_o.left    = ctl_i.left - 8'd1;
                taken         = 1'b1;
              end
            end
            default: begin
              if (ctl_i.left == 8'd0) begin
                ctl_o.phase = PH_P_L;
              end else begin
                ctl_o.bit_idx = '0;
                ctl_o.shift   = '0;
                ctl_o.phase   = PH_RX_L;
              end
            end
          endcase
        end
      end else begin
        case (ctl_i.phase)
          PH_ST_A: ctl_o.phase = req_i.sda_in ? PH_ST_B : PH_F_L;
          PH_ST_B: ctl_o.phase = req_i.sda_in ? PH_F_L : PH_ST_C;
          PH_ST_C: begin
            ctl_o.phase   = PH_TXA_L;
            ctl_o.shift   = {ctl_i.dev, 1'b0};
            ctl_o.bit_idx = '0;
          end
          PH_RS_P: ctl_o.phase = PH_RS_A;
          PH_RS_A: ctl_o.phase = PH_RS_B;
          PH_RS_B: ctl_o.phase = PH_RS_C;
          PH_RS_C: begin
            ctl_o.phase   = PH_TXAR_L;
            ctl_o.shift   = {ctl_i.dev, 1'b1};
            ctl_o.bit_idx = '0;
          end
          PH_RX_L: ctl_o.phase = PH_RX_H;
          PH_RX_H: begin
            if (ctl_i.bit_idx < 4'd8) begin
              ctl_o.shift   = {ctl_i.shift[6:0], req_i.sda_in};
              ctl_o.bit_idx = bit_inc;
              if (bit_inc == 4'd8) begin
                valid      = 1'b1;
                ctl_o.left = ctl_i.left - 8'd1;
              end
              ctl_o.phase = PH_RX_L;
            end else if (ctl_i.left == 8'd0) begin
              ctl_o.phase = PH_P_L;
            end else begin
              ctl_o.bit_idx = '0;
              ctl_o.phase   = PH_RX_L;
            end
          end
          PH_P_L: ctl_o.phase = PH_P_H;
          PH_P_H: ctl_o.phase = PH_P_R;
          PH_F_L: ctl_o.phase = PH_F_H;
          PH_F_H: ctl_o.phase = PH_F_R;
          PH_P_R, PH_F_R: begin
            done        = 1'b1;
            fail        = (ctl_i.phase == PH_F_R);
            ctl_o.phase = PH_IDLE;
          end
          default: ctl_o.phase = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    s                = ctl_o.phase;
    res_o.scl_out    = 1'b1;
    res_o.sda_out    = 1'b1;
    res_o.sda_drive  = 1'b1;
    if (s inside {[PH_TXA_L:PH_TXAR_H]}) begin
      res_o.scl_out = s[0];
      if (ctl_o.bit_idx < 4'd8) res_o.sda_out = ctl_o.shift[7];
      else res_o.sda_drive = 1'b0;
    end else if (s == PH_RX_L || s == PH_RX_H) begin
      res_o.scl_out = (s == PH_RX_H);
      if (ctl_o.bit_idx < 4'd8) res_o.sda_drive = 1'b0;
      else res_o.sda_out = (ctl_o.left == 8'd0);
    end else begin
      case (s)
        PH_ST_B, PH_RS_B, PH_P_H, PH_F_H: res_o.sda_out = 1'b0;
        PH_ST_C, PH_RS_C, PH_P_L, PH_F_L: begin
          res_o.scl_out = 1'b0;
          res_o.sda_out = 1'b0;
        end
        PH_RS_P: res_o.scl_out = 1'b0;
        default: ;
      endcase
    end
    res_o.busy_res   = (s != PH_IDLE);
    res_o.byte_taken = taken;
    res_o.rd_byte    = valid ? ctl_o.shift : 8'd0;
    res_o.rd_valid   = valid;
    res_o.done_res   = done;
    res_o.status     = fail;
  end

endmodule

`default_nettype wire

// ----- src/i2c_master_register_burst_top.sv -----
// Top level of the I2C register-burst master: stream ports, control state, result register.
// Depends on i2cm_pkg, i2cm_cfg and i2cm_step.
`timescale 1ns / 1ps
`default_nettype none

// Each input word is one bus tick: it carries the request fields and the sampled SDA level,
// and yields exactly one result word with the pin levels and event pulses after that tick.
// One word is taken per clock; the tick logic sits between the control-state registers and
// a single output register; the rate is one word per cycle while the output side keeps up.
// Phases last phase_ticks words (read data bits twice that), and go is ignored while a
// transaction is running. Configuration writes apply at once.
module i2c_master_register_burst_top
  import i2cm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // go, func, dev_addr[6:0], reg_addr[7:0], byte_count[7:0], wr_byte[7:0], sda_in, zero pad
  input  wire logic [39:0] s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // scl_out, sda_out, sda_drive, busy_res, byte_taken, rd_byte[7:0], rd_valid, done_res, status
  output      logic [15:0] m_axis_tdata
);

  cfg_t        cfg;
  req_t        req;
  res_t        res;
  ctl_t        ctl_q;
  ctl_t        ctl_d;
  logic        acc;
  logic        out_valid_q;
  logic [15:0] out_data_q;

  i2cm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign req.go         = s_axis_tdata[0];
  assign req.func       = s_axis_tdata[1];
  assign req.dev_addr   = s_axis_tdata[8:2];
  assign req.reg_addr   = s_axis_tdata[16:9];
  assign req.byte_count = s_axis_tdata[24:17];
  assign req.wr_byte    = s_axis_tdata[32:25];
  assign req.sda_in     = s_axis_tdata[33];

  i2cm_step u_step (
    .ctl_i (ctl_q),
    .cfg_i (cfg),
    .req_i (req),
    .ctl_o (ctl_d),
    .res_o (res)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        ctl_q       <= ctl_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_data_q <= {res.status, res.done_res, res.rd_valid, res.rd_byte, res.byte_taken,
                     res.busy_res, res.sda_drive, res.sda_out, res.scl_out};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[14]) |-> !m_axis_tdata[3])
    else $error("done pulse while still busy");

  a_released_sda_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[2]) |-> m_axis_tdata[1])
    else $error("sda_out low while SDA released");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && ctl_q.phase == PH_IDLE && !req.go) |=> (ctl_q.phase == PH_IDLE))
    else $error("left idle without go");

  a_taken_not_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[13]))
    else $error("byte_taken and rd_valid together");
`endif

endmodule

`default_nettype wire
